[rtl/mxt_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// mxt_pkg
// types and constants shared by the max subarray xor trie block
// ----------------------------------------------------------------------------
package mxt_pkg;

	localparam int unsigned DATA_W = 32;

	typedef struct packed {
		logic [DATA_W-1:0] element;
		logic              start_req;
	} mxt_in_t;

	typedef struct packed {
		logic [DATA_W-1:0] best_ending_here;
		logic [DATA_W-1:0] best_so_far;
		logic              out_of_nodes;
	} mxt_out_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHAIN,
		ST_Q_START,
		ST_Q_WALK,
		ST_I_START,
		ST_I_WALK,
		ST_DONE
	} mxt_state_t;

endpackage
`default_nettype wire

[rtl/max_subarray_xor_trie_top.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// max_subarray_xor_trie_top
// streaming maximum subarray xor over a binary trie of prefix xors
//
//   channel   signals                 direction   handshake
//   request   start, busy, req        in          beat taken when start & !busy
//   result    done, result            out         one-cycle strobe, no stall
//
// one beat at a time; busy stays high until its result strobe
// query walk: one node memory read per trie level
// insert: one read per level to the path end, one write per new node plus one to link the parent
// a new array (or first beat after reset) first writes the seed path
// reset clears all registers but the node memory and its read data; node memory is written before it is read
// ----------------------------------------------------------------------------
module max_subarray_xor_trie_top #(
	parameter int unsigned KEY_BITS   = 32,
	parameter int unsigned NODE_COUNT = 32768
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	output logic                  busy,
	input  wire mxt_pkg::mxt_in_t req,
	output logic                  done,
	output mxt_pkg::mxt_out_t     result
);
	import mxt_pkg::*;

	localparam int unsigned IW = $clog2(NODE_COUNT);
	localparam int unsigned CW = $clog2(NODE_COUNT + 1);
	localparam int unsigned LW = $clog2(KEY_BITS + 1);
	localparam int unsigned KW = (KEY_BITS > 1) ? $clog2(KEY_BITS) : 1;

	mxt_state_t state_q, state_d;

	logic [KEY_BITS-1:0] prefix_q;
	logic [KEY_BITS-1:0] best_q;
	logic [KEY_BITS-1:0] here_q;
	logic [KEY_BITS-1:0] acc_q;
	logic [CW-1:0]       used_q;
	logic                pool_full_q;
	logic                seeding_q;
	logic [LW-1:0]       lvl_q;
	logic [IW-1:0]       cur_q;

	// node memory: {child1, child0}
	logic [2*IW-1:0] node_mem [NODE_COUNT];
	logic [2*IW-1:0] rdata_q;
	logic            rd_en, wr_en;
	logic [IW-1:0]   rd_addr, wr_addr;
	logic [2*IW-1:0] wr_data;

	logic [IW-1:0]       c0, c1, q_other, q_same, node_idx, node_nxt;
	logic [KW-1:0]       lvl_idx, dec_idx;
	logic [LW-1:0]       lvl_dec;
	logic                pbit, ckey, lvl_zero, finish, no_room, accept, seed_now;
	logic [KEY_BITS-1:0] onehot, acc_new, prefix_base;
	logic [2*IW-1:0]     chain_data, parent_data;

	assign accept   = start && !busy;
	assign c0       = rdata_q[IW-1:0];
	assign c1       = rdata_q[2*IW-1:IW];
	assign lvl_idx  = lvl_q[KW-1:0];
	assign lvl_dec  = lvl_q - 1'b1;
	assign dec_idx  = lvl_dec[KW-1:0];
	assign lvl_zero = (lvl_q == '0);
	assign pbit     = prefix_q[lvl_idx];
	assign q_other  = pbit ? c0 : c1;
	assign q_same   = pbit ? c1 : c0;
	assign onehot   = KEY_BITS'(1) << lvl_idx;
	assign acc_new  = (q_other != '0) ? (acc_q | onehot) : acc_q;
	assign finish   = lvl_zero || ((q_other == '0) && (q_same == '0));
	assign no_room  = ({1'b0, used_q} + (CW+1)'(lvl_q) + (CW+1)'(1)) > (CW+1)'(NODE_COUNT);
	assign node_idx = used_q[IW-1:0];
	assign node_nxt = node_idx + 1'b1;
	assign ckey     = seeding_q ? 1'b0 : prefix_q[dec_idx];
	assign chain_data  = lvl_zero ? '0 :
		(ckey ? {node_nxt, {IW{1'b0}}} : {{IW{1'b0}}, node_nxt});
	assign parent_data = pbit ? {node_idx, c0} : {c1, node_idx};
	assign seed_now    = req.start_req || (used_q == '0);
	assign prefix_base = req.start_req ? '0 : prefix_q;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and memory control
	always_comb begin
		state_d = state_q;
		rd_en   = 1'b0;
		rd_addr = '0;
		wr_en   = 1'b0;
		wr_addr = node_idx;
		wr_data = chain_data;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_d = seed_now ? ST_CHAIN : ST_Q_START;
				end
			end
			ST_CHAIN: begin
				wr_en = 1'b1;
				if (lvl_zero) begin
					state_d = seeding_q ? ST_Q_START : ST_DONE;
				end
			end
			ST_Q_START: begin
				rd_en   = 1'b1;
				state_d = ST_Q_WALK;
			end
			ST_Q_WALK: begin
				if (finish) begin
					state_d = pool_full_q ? ST_DONE : ST_I_START;
				end else begin
					rd_en   = 1'b1;
					rd_addr = (q_other != '0) ? q_other : q_same;
				end
			end
			ST_I_START: begin
				rd_en   = 1'b1;
				state_d = ST_I_WALK;
			end
			ST_I_WALK: begin
				if (q_same == '0) begin
					if (no_room) begin
						state_d = ST_DONE;
					end else begin
						wr_en   = 1'b1;
						wr_addr = cur_q;
						wr_data = parent_data;
						state_d = ST_CHAIN;
					end
				end else if (lvl_zero) begin
					state_d = ST_DONE;
				end else begin
					rd_en   = 1'b1;
					rd_addr = q_same;
				end
			end
			ST_DONE: begin
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// node memory
	always_ff @(posedge clk) begin
		if (wr_en) begin
			node_mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rdata_q <= node_mem[rd_addr];
		end
	end

	// datapath and counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prefix_q    <= '0;
			best_q      <= '0;
			here_q      <= '0;
			acc_q       <= '0;
			used_q      <= '0;
			pool_full_q <= 1'b0;
			seeding_q   <= 1'b0;
			lvl_q       <= '0;
			cur_q       <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						prefix_q <= prefix_base ^ req.element[KEY_BITS-1:0];
						if (req.start_req) begin
							used_q      <= '0;
							best_q      <= '0;
							pool_full_q <= 1'b0;
						end
						if (seed_now) begin
							seeding_q <= 1'b1;
							lvl_q     <= LW'(KEY_BITS);
						end
					end
				end
				ST_CHAIN: begin
					used_q <= used_q + 1'b1;
					if (lvl_zero) begin
						seeding_q <= 1'b0;
					end else begin
						lvl_q <= lvl_dec;
					end
				end
				ST_Q_START: begin
					lvl_q <= LW'(KEY_BITS - 1);
					acc_q <= '0;
				end
				ST_Q_WALK: begin
					acc_q <= acc_new;
					if (finish) begin
						here_q <= acc_new;
						if (acc_new > best_q) begin
							best_q <= acc_new;
						end
					end else begin
						lvl_q <= lvl_dec;
					end
				end
				ST_I_START: begin
					lvl_q <= LW'(KEY_BITS - 1);
					cur_q <= '0;
				end
				ST_I_WALK: begin
					if (q_same == '0) begin
						if (no_room) begin
							pool_full_q <= 1'b1;
						end
					end else if (!lvl_zero) begin
						cur_q <= q_same;
						lvl_q <= lvl_dec;
					end
				end
				default: begin
				end
			endcase
		end
	end

	assign busy                    = (state_q != ST_IDLE);
	assign done                    = (state_q == ST_DONE);
	assign result.best_ending_here = DATA_W'(here_q);
	assign result.best_so_far      = DATA_W'(best_q);
	assign result.out_of_nodes     = pool_full_q;

	// checks
	a_best_covers_here: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (result.best_so_far >= result.best_ending_here))
		else $error("best_so_far below best_ending_here");

	a_pool_bound: assert property (@(posedge clk) disable iff (!arst_n)
		used_q <= CW'(NODE_COUNT))
		else $error("node count beyond pool size");

	a_chain_room: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CHAIN) |-> (used_q < CW'(NODE_COUNT)))
		else $error("node write beyond pool");

	a_single_strobe: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> (!done && !busy))
		else $error("result strobe longer than one cycle");

	a_full_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(pool_full_q) |-> $past(accept && req.start_req))
		else $error("pool full flag cleared without new array");

endmodule
`default_nettype wire
